### rtl/core/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/pmsc_pkg.sv
// Shared constants, types and state encoding of the pooled mean/deviation combiner.
package pmsc_pkg;

  localparam int MAX_GROUPS_DEF = 64;
  localparam int VAL_W          = 24;
  localparam int CNT_W          = 16;
  localparam int TOTAL_W        = 22;
  localparam int WIN_W          = 16;
  localparam int SQ_W           = 2 * VAL_W;

  localparam logic [WIN_W-1:0]   WIN_RESET = WIN_W'(10);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] std;
    logic [CNT_W-1:0] count;
  } group_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SIDE,
    ST_DIV_MEAN,
    ST_DIV_IOPS,
    ST_GRP_RD,
    ST_GRP_MAC,
    ST_VAR_GO,
    ST_DIV_VAR,
    ST_SQRT,
    ST_OUT
  } state_t;

endpackage

### rtl/core/pmsc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pmsc_div #(
  parameter int DW = 8,
  parameter int NW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsr;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          run;
  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          fits;

  assign trial    = {rem, quo[DW-1]};
  assign diff     = trial - {1'b0, dsr};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (run) begin
      rem <= fits ? diff[NW-1:0] : trial[NW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

### rtl/core/pmsc_sqrt.sv
// Digit-serial floor square root, two radicand bits per cycle.
module pmsc_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pmsc_pkg::SQ_W-1:0] radicand,
  output logic                      done,
  output logic [pmsc_pkg::VAL_W-1:0] root
);

  localparam int RW = pmsc_pkg::VAL_W + 1;
  localparam int CW = $clog2(pmsc_pkg::VAL_W + 1);

  logic [pmsc_pkg::SQ_W-1:0]  val;
  logic [RW-1:0]              rem;
  logic [CW-1:0]              cnt;
  logic                       run;
  logic [RW+1:0]              r4;
  logic [RW+1:0]              trial;
  logic                       fits;

  assign r4    = {rem, val[pmsc_pkg::SQ_W-1 -: 2]};
  assign trial = (RW+2)'({root, 2'b01});
  assign fits  = r4 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(pmsc_pkg::VAL_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      val <= {val[pmsc_pkg::SQ_W-3:0], 2'b00};
      if (fits) begin
        rem  <= RW'(r4 - trial);
        root <= {root[pmsc_pkg::VAL_W-2:0], 1'b1};
      end else begin
        rem  <= r4[RW-1:0];
        root <= {root[pmsc_pkg::VAL_W-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/core/pooled_mean_stddev_combiner.sv
// Top level of the pooled mean and standard deviation combiner.
// Usage:
//   Input channel (in_valid/in_ready) takes one group summary per beat. Each
//   beat is taken and stored in the group memories in ST_IDLE, then ST_LOAD
//   folds mean*count and iops*count into the accumulators through the one
//   shared multiplier; in_ready stays low until that fold is done. Beats
//   beyond MAX_GROUPS are dropped and flagged. A beat with last_group set
//   starts the closing pass. For each side with a nonzero count it runs two
//   serial divisions, a pass over the stored groups (ST_GRP_RD, ST_GRP_MAC
//   per group), a third division and a serial square root. The divider
//   takes one quotient bit a cycle. The result lands in an output register
//   (out_valid/out_ready); a new set may load while it waits. A stalled
//   receiver only holds a second closing pass before its output load.
//   Config channel (cfg_valid/cfg_ready, always ready) writes window_seconds.
//   Reset (rst, synchronous) empties the set, drops any pending result and
//   sets the window to 10.
module pooled_mean_stddev_combiner #(
  parameter int MAX_GROUPS = pmsc_pkg::MAX_GROUPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          read_present,
  input  logic [pmsc_pkg::VAL_W-1:0]    read_mean,
  input  logic [pmsc_pkg::VAL_W-1:0]    read_std,
  input  logic [pmsc_pkg::VAL_W-1:0]    read_iops,
  input  logic [pmsc_pkg::CNT_W-1:0]    read_count,
  input  logic                          write_present,
  input  logic [pmsc_pkg::VAL_W-1:0]    write_mean,
  input  logic [pmsc_pkg::VAL_W-1:0]    write_std,
  input  logic [pmsc_pkg::VAL_W-1:0]    write_iops,
  input  logic [pmsc_pkg::CNT_W-1:0]    write_count,
  input  logic                          last_group,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          read_valid,
  output logic [pmsc_pkg::VAL_W-1:0]    pooled_read_mean,
  output logic [pmsc_pkg::VAL_W-1:0]    pooled_read_std,
  output logic [pmsc_pkg::VAL_W-1:0]    pooled_read_iops,
  output logic [pmsc_pkg::TOTAL_W-1:0]  read_total,
  output logic                          write_valid,
  output logic [pmsc_pkg::VAL_W-1:0]    pooled_write_mean,
  output logic [pmsc_pkg::VAL_W-1:0]    pooled_write_std,
  output logic [pmsc_pkg::VAL_W-1:0]    pooled_write_iops,
  output logic [pmsc_pkg::TOTAL_W-1:0]  write_total,
  output logic [pmsc_pkg::WIN_W-1:0]    window_out,
  output logic                          overflowed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmsc_pkg::WIN_W-1:0]    window_seconds
);

  localparam int VW    = pmsc_pkg::VAL_W;
  localparam int AW    = $clog2(MAX_GROUPS);
  localparam int GW    = $clog2(MAX_GROUPS + 1);
  localparam int NW    = pmsc_pkg::CNT_W + AW;
  localparam int ACCW  = VW + pmsc_pkg::CNT_W + AW;
  localparam int SUMW  = 2 * VW + 1 + pmsc_pkg::CNT_W + AW;
  localparam int MW    = VW + 1;
  localparam int TW    = 2 * VW + 1;
  localparam int TOTW  = NW + pmsc_pkg::TOTAL_W;
  localparam int LOAD_LAST = 4;
  localparam int GRP_LAST  = 5;

  pmsc_pkg::state_t state, state_next;

  pmsc_pkg::group_t mem_rd [MAX_GROUPS];
  pmsc_pkg::group_t mem_wr [MAX_GROUPS];
  pmsc_pkg::group_t rdata_rd, rdata_wr, rdata;

  logic [pmsc_pkg::WIN_W-1:0] window;
  logic [ACCW-1:0]  acc_mean [2];
  logic [ACCW-1:0]  acc_iops [2];
  logic [NW-1:0]    acc_cnt  [2];
  logic [GW-1:0]    gc;
  logic [GW-1:0]    g;
  logic             ovf;
  logic             last_pend;
  logic [2:0]       mstep;
  logic [2:0]       gstep;
  logic             side;

  logic [VW-1:0]             it_mean [2];
  logic [VW-1:0]             it_iops [2];
  logic [pmsc_pkg::CNT_W-1:0] it_cnt [2];

  logic [MW-1:0]    mul_a, mul_b;
  logic [2*MW-1:0]  prod;
  logic [TW-1:0]    t;
  logic [SUMW-1:0]  sum;
  logic [VW-1:0]    mean_q, iops_q;
  logic [VW-1:0]    dev;

  logic                       res_valid [2];
  logic [VW-1:0]              res_mean [2];
  logic [VW-1:0]              res_std  [2];
  logic [VW-1:0]              res_iops [2];
  logic [pmsc_pkg::TOTAL_W-1:0] res_tot [2];

  logic             in_fire, store_en, out_load, grp_end;
  logic [NW-1:0]    n_cur;
  logic [TOTW-1:0]  n_wide;
  logic             div_start, div_done, sqrt_start, sqrt_done;
  logic [SUMW-1:0]  div_dividend, div_quo;
  logic [pmsc_pkg::SQ_W-1:0] sq_in;
  logic [VW-1:0]    sq_root;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign store_en  = in_fire && (gc < GW'(MAX_GROUPS));
  assign out_load  = (state == pmsc_pkg::ST_OUT) && (!out_valid || out_ready);
  assign grp_end   = (GW'(g + 1'b1) == gc);
  assign n_cur     = acc_cnt[side];
  assign n_wide    = TOTW'(n_cur);
  assign rdata     = side ? rdata_wr : rdata_rd;
  assign dev       = (rdata.mean >= mean_q) ? rdata.mean - mean_q : mean_q - rdata.mean;
  assign sq_in     = (|div_quo[SUMW-1:pmsc_pkg::SQ_W]) ? '1 : div_quo[pmsc_pkg::SQ_W-1:0];

  pmsc_div #(.DW(SUMW), .NW(NW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_cur),
    .done     (div_done),
    .quotient (div_quo)
  );

  pmsc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_in),
    .done     (sqrt_done),
    .root     (sq_root)
  );

  // Group memories: one write port at load, one registered read in the closing pass.
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem_rd[gc[AW-1:0]] <= '{mean: read_mean, std: read_std,
                              count: read_present ? read_count : '0};
      mem_wr[gc[AW-1:0]] <= '{mean: write_mean, std: write_std,
                              count: write_present ? write_count : '0};
    end
    rdata_rd <= mem_rd[g[AW-1:0]];
    rdata_wr <= mem_wr[g[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pmsc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (store_en)        state_next = pmsc_pkg::ST_LOAD;
          else if (last_group) state_next = pmsc_pkg::ST_SIDE;
        end
      end
      pmsc_pkg::ST_LOAD: begin
        if (mstep == 3'(LOAD_LAST))
          state_next = last_pend ? pmsc_pkg::ST_SIDE : pmsc_pkg::ST_IDLE;
      end
      pmsc_pkg::ST_SIDE: begin
        if (n_cur != '0)  state_next = pmsc_pkg::ST_DIV_MEAN;
        else if (side)    state_next = pmsc_pkg::ST_OUT;
      end
      pmsc_pkg::ST_DIV_MEAN: if (div_done) state_next = pmsc_pkg::ST_DIV_IOPS;
      pmsc_pkg::ST_DIV_IOPS: if (div_done) state_next = pmsc_pkg::ST_GRP_RD;
      pmsc_pkg::ST_GRP_RD:   state_next = pmsc_pkg::ST_GRP_MAC;
      pmsc_pkg::ST_GRP_MAC: begin
        if (gstep == 3'(GRP_LAST))
          state_next = grp_end ? pmsc_pkg::ST_VAR_GO : pmsc_pkg::ST_GRP_RD;
      end
      pmsc_pkg::ST_VAR_GO:   state_next = pmsc_pkg::ST_DIV_VAR;
      pmsc_pkg::ST_DIV_VAR:  if (div_done) state_next = pmsc_pkg::ST_SQRT;
      pmsc_pkg::ST_SQRT: begin
        if (sqrt_done) state_next = side ? pmsc_pkg::ST_OUT : pmsc_pkg::ST_SIDE;
      end
      pmsc_pkg::ST_OUT:      if (out_load) state_next = pmsc_pkg::ST_IDLE;
      default:               state_next = pmsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    sqrt_start   = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      pmsc_pkg::ST_IDLE: in_ready = 1'b1;
      pmsc_pkg::ST_LOAD: begin
        case (mstep)
          3'd0: begin mul_a = MW'(it_mean[0]); mul_b = MW'(it_cnt[0]); end
          3'd1: begin mul_a = MW'(it_iops[0]); mul_b = MW'(it_cnt[0]); end
          3'd2: begin mul_a = MW'(it_mean[1]); mul_b = MW'(it_cnt[1]); end
          3'd3: begin mul_a = MW'(it_iops[1]); mul_b = MW'(it_cnt[1]); end
          default: ;
        endcase
      end
      pmsc_pkg::ST_SIDE: begin
        if (n_cur != '0) begin
          div_start    = 1'b1;
          div_dividend = SUMW'(acc_mean[side]);
        end
      end
      pmsc_pkg::ST_DIV_MEAN: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = SUMW'(acc_iops[side]);
        end
      end
      pmsc_pkg::ST_GRP_MAC: begin
        case (gstep)
          3'd0: begin mul_a = MW'(rdata.std);    mul_b = MW'(rdata.std); end
          3'd1: begin mul_a = MW'(dev);          mul_b = MW'(dev); end
          3'd3: begin mul_a = t[MW-1:0];         mul_b = MW'(rdata.count); end
          3'd4: begin mul_a = MW'(t[TW-1:MW]);   mul_b = MW'(rdata.count); end
          default: ;
        endcase
      end
      pmsc_pkg::ST_VAR_GO: begin
        div_start    = 1'b1;
        div_dividend = sum;
      end
      pmsc_pkg::ST_DIV_VAR: sqrt_start = div_done;
      default: ;
    endcase
  end

  // Control state and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pmsc_pkg::ST_IDLE;
      window    <= pmsc_pkg::WIN_RESET;
      acc_mean  <= '{default: '0};
      acc_iops  <= '{default: '0};
      acc_cnt   <= '{default: '0};
      gc        <= '0;
      g         <= '0;
      ovf       <= 1'b0;
      last_pend <= 1'b0;
      mstep     <= '0;
      gstep     <= '0;
      side      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) window <= window_seconds;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        pmsc_pkg::ST_IDLE: begin
          if (in_fire) begin
            last_pend <= last_group;
            mstep     <= '0;
            if (store_en) begin
              gc         <= gc + 1'b1;
              acc_cnt[0] <= acc_cnt[0] + NW'(read_present ? read_count : '0);
              acc_cnt[1] <= acc_cnt[1] + NW'(write_present ? write_count : '0);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        pmsc_pkg::ST_LOAD: begin
          mstep <= mstep + 1'b1;
          // Fold the product issued in the previous step.
          case (mstep)
            3'd1: acc_mean[0] <= acc_mean[0] + ACCW'(prod);
            3'd2: acc_iops[0] <= acc_iops[0] + ACCW'(prod);
            3'd3: acc_mean[1] <= acc_mean[1] + ACCW'(prod);
            3'd4: acc_iops[1] <= acc_iops[1] + ACCW'(prod);
            default: ;
          endcase
        end
        pmsc_pkg::ST_SIDE: begin
          if (n_cur == '0) side <= 1'b1;
          g <= '0;
        end
        pmsc_pkg::ST_GRP_RD: gstep <= '0;
        pmsc_pkg::ST_GRP_MAC: begin
          gstep <= gstep + 1'b1;
          if (gstep == 3'(GRP_LAST) && !grp_end) g <= g + 1'b1;
        end
        pmsc_pkg::ST_SQRT: if (sqrt_done) side <= 1'b1;
        pmsc_pkg::ST_OUT: begin
          if (out_load) begin
            acc_mean  <= '{default: '0};
            acc_iops  <= '{default: '0};
            acc_cnt   <= '{default: '0};
            gc        <= '0;
            ovf       <= 1'b0;
            side      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_fire) begin
      it_mean[0] <= read_mean;
      it_iops[0] <= read_iops;
      it_cnt[0]  <= read_present ? read_count : '0;
      it_mean[1] <= write_mean;
      it_iops[1] <= write_iops;
      it_cnt[1]  <= write_present ? write_count : '0;
    end
    if (state == pmsc_pkg::ST_SIDE && n_cur == '0) begin
      res_valid[side] <= 1'b0;
      res_mean[side]  <= '0;
      res_std[side]   <= '0;
      res_iops[side]  <= '0;
      res_tot[side]   <= '0;
    end
    if (state == pmsc_pkg::ST_DIV_MEAN && div_done) mean_q <= div_quo[VW-1:0];
    if (state == pmsc_pkg::ST_DIV_IOPS && div_done) begin
      iops_q <= div_quo[VW-1:0];
      sum    <= '0;
    end
    if (state == pmsc_pkg::ST_GRP_MAC) begin
      case (gstep)
        3'd1: t   <= TW'(prod);
        3'd2: t   <= t + TW'(prod);
        3'd4: sum <= sum + SUMW'(prod);
        3'd5: sum <= sum + (SUMW'(prod) << MW);
        default: ;
      endcase
    end
    if (state == pmsc_pkg::ST_SQRT && sqrt_done) begin
      res_valid[side] <= 1'b1;
      res_mean[side]  <= mean_q;
      res_std[side]   <= sq_root;
      res_iops[side]  <= iops_q;
      res_tot[side]   <= (n_wide > TOTW'(pmsc_pkg::TOTAL_MAX)) ? pmsc_pkg::TOTAL_MAX
                                                               : n_wide[pmsc_pkg::TOTAL_W-1:0];
    end
    if (out_load) begin
      read_valid        <= res_valid[0];
      pooled_read_mean  <= res_mean[0];
      pooled_read_std   <= res_std[0];
      pooled_read_iops  <= res_iops[0];
      read_total        <= res_tot[0];
      write_valid       <= res_valid[1];
      pooled_write_mean <= res_mean[1];
      pooled_write_std  <= res_std[1];
      pooled_write_iops <= res_iops[1];
      write_total       <= res_tot[1];
      window_out        <= window;
      overflowed        <= ovf;
    end
  end

endmodule

### rtl/core/pmsc_checker.sv
// Port-level checker for the combiner, bound to the top level.
`include "assert_macros.svh"

module pmsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          read_present,
  input logic [pmsc_pkg::VAL_W-1:0]    read_mean,
  input logic [pmsc_pkg::VAL_W-1:0]    read_std,
  input logic [pmsc_pkg::VAL_W-1:0]    read_iops,
  input logic [pmsc_pkg::CNT_W-1:0]    read_count,
  input logic                          write_present,
  input logic [pmsc_pkg::VAL_W-1:0]    write_mean,
  input logic [pmsc_pkg::VAL_W-1:0]    write_std,
  input logic [pmsc_pkg::VAL_W-1:0]    write_iops,
  input logic [pmsc_pkg::CNT_W-1:0]    write_count,
  input logic                          last_group,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          read_valid,
  input logic [pmsc_pkg::VAL_W-1:0]    pooled_read_mean,
  input logic [pmsc_pkg::VAL_W-1:0]    pooled_read_std,
  input logic [pmsc_pkg::VAL_W-1:0]    pooled_read_iops,
  input logic [pmsc_pkg::TOTAL_W-1:0]  read_total,
  input logic                          write_valid,
  input logic [pmsc_pkg::VAL_W-1:0]    pooled_write_mean,
  input logic [pmsc_pkg::VAL_W-1:0]    pooled_write_std,
  input logic [pmsc_pkg::VAL_W-1:0]    pooled_write_iops,
  input logic [pmsc_pkg::TOTAL_W-1:0]  write_total,
  input logic [pmsc_pkg::WIN_W-1:0]    window_out,
  input logic                          overflowed,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [pmsc_pkg::WIN_W-1:0]    window_seconds
);

  `ASSERT_ALWAYS(a_reset_drops_result, rst |=> !out_valid, "result beat survived reset")

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(read_total) && $stable(pooled_write_std), "stalled result beat changed")

  `ASSERT_CLK(a_read_invalid_zero, out_valid && !read_valid |-> pooled_read_mean == '0 && pooled_read_std == '0 && pooled_read_iops == '0 && read_total == '0, "invalid read side carries data")

  `ASSERT_CLK(a_write_invalid_zero, out_valid && !write_valid |-> pooled_write_mean == '0 && pooled_write_std == '0 && pooled_write_iops == '0 && write_total == '0, "invalid write side carries data")

  `ASSERT_CLK(a_valid_has_total, out_valid && (read_valid || write_valid) |-> (!read_valid || read_total != '0) && (!write_valid || write_total != '0), "valid side with zero total")

endmodule

bind pooled_mean_stddev_combiner pmsc_checker u_pmsc_checker (.*);

### dv/pooled_stats_checker.sv
// Checker for the pooled mean/deviation combiner: predicts each set summary and compares.
`timescale 1ns / 100ps

module pooled_stats_checker #(
  parameter int MAX_GROUPS = pmsc_pkg::MAX_GROUPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         read_present,
  input  logic [pmsc_pkg::VAL_W-1:0]   read_mean,
  input  logic [pmsc_pkg::VAL_W-1:0]   read_std,
  input  logic [pmsc_pkg::VAL_W-1:0]   read_iops,
  input  logic [pmsc_pkg::CNT_W-1:0]   read_count,
  input  logic                         write_present,
  input  logic [pmsc_pkg::VAL_W-1:0]   write_mean,
  input  logic [pmsc_pkg::VAL_W-1:0]   write_std,
  input  logic [pmsc_pkg::VAL_W-1:0]   write_iops,
  input  logic [pmsc_pkg::CNT_W-1:0]   write_count,
  input  logic                         last_group,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         read_valid,
  input  logic [pmsc_pkg::VAL_W-1:0]   pooled_read_mean,
  input  logic [pmsc_pkg::VAL_W-1:0]   pooled_read_std,
  input  logic [pmsc_pkg::VAL_W-1:0]   pooled_read_iops,
  input  logic [pmsc_pkg::TOTAL_W-1:0] read_total,
  input  logic                         write_valid,
  input  logic [pmsc_pkg::VAL_W-1:0]   pooled_write_mean,
  input  logic [pmsc_pkg::VAL_W-1:0]   pooled_write_std,
  input  logic [pmsc_pkg::VAL_W-1:0]   pooled_write_iops,
  input  logic [pmsc_pkg::TOTAL_W-1:0] write_total,
  input  logic [pmsc_pkg::WIN_W-1:0]   window_out,
  input  logic                         overflowed,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [pmsc_pkg::WIN_W-1:0]   window_seconds,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic                         ok;
    logic [pmsc_pkg::VAL_W-1:0]   mean;
    logic [pmsc_pkg::VAL_W-1:0]   std;
    logic [pmsc_pkg::VAL_W-1:0]   iops;
    logic [pmsc_pkg::TOTAL_W-1:0] total;
  } side_sum_t;

  typedef struct packed {
    side_sum_t                  rd;
    side_sum_t                  wr;
    logic [pmsc_pkg::WIN_W-1:0] win;
    logic                       ovf;
  } set_summary_t;

  pmsc_pkg::group_t           rd_groups [MAX_GROUPS];
  pmsc_pkg::group_t           wr_groups [MAX_GROUPS];
  logic [63:0]                rd_mean_sum, rd_iops_sum, rd_cnt_sum;
  logic [63:0]                wr_mean_sum, wr_iops_sum, wr_cnt_sum;
  int                         n_groups;
  logic                       dropped;
  logic [pmsc_pkg::WIN_W-1:0] win_reg;
  set_summary_t               expected_summaries [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [31:0]  r;
    logic [31:0]  trial;
    logic [127:0] sq;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (32'd1 << i);
      sq = 128'(trial) * 128'(trial);
      if (sq <= 128'(v)) r = trial;
    end
    return 64'(r);
  endfunction

  function automatic side_sum_t pool_side(input bit wr_side);
    side_sum_t        s;
    logic [63:0]      n, m, io, mg, sg, d, var_q, sd;
    logic [127:0]     acc, q;
    pmsc_pkg::group_t g;
    s = '0;
    n = wr_side ? wr_cnt_sum : rd_cnt_sum;
    if (n == 0) return s;
    m  = (wr_side ? wr_mean_sum : rd_mean_sum) / n;
    io = (wr_side ? wr_iops_sum : rd_iops_sum) / n;
    acc = '0;
    for (int i = 0; i < n_groups; i++) begin
      g  = wr_side ? wr_groups[i] : rd_groups[i];
      mg = 64'(g.mean);
      sg = 64'(g.std);
      d  = (mg >= m) ? mg - m : m - mg;
      acc += 128'(sg * sg + d * d) * 128'(g.count);
    end
    q = acc / 128'(n);
    var_q = (q[127:64] != 0) ? '1 : q[63:0];
    sd = floor_sqrt(var_q);
    s.ok    = 1'b1;
    s.mean  = (m  > 64'hFFFFFF) ? '1 : m[pmsc_pkg::VAL_W-1:0];
    s.std   = (sd > 64'hFFFFFF) ? '1 : sd[pmsc_pkg::VAL_W-1:0];
    s.iops  = (io > 64'hFFFFFF) ? '1 : io[pmsc_pkg::VAL_W-1:0];
    s.total = (n > 64'(pmsc_pkg::TOTAL_MAX)) ? pmsc_pkg::TOTAL_MAX
                                             : n[pmsc_pkg::TOTAL_W-1:0];
    return s;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    set_summary_t               e;
    logic [pmsc_pkg::CNT_W-1:0] rc, wc;
    if (rst) begin
      rd_mean_sum = 0; rd_iops_sum = 0; rd_cnt_sum = 0;
      wr_mean_sum = 0; wr_iops_sum = 0; wr_cnt_sum = 0;
      n_groups = 0;
      dropped  = 0;
      win_reg  = pmsc_pkg::WIN_RESET;
      expected_summaries.delete();
    end else begin
      if (cfg_valid && cfg_ready) win_reg = window_seconds;
      if (in_valid && in_ready) begin
        // an absent side counts as zero samples
        rc = read_present ? read_count : '0;
        wc = write_present ? write_count : '0;
        if (n_groups < MAX_GROUPS) begin
          rd_groups[n_groups] = '{mean: read_mean, std: read_std, count: rc};
          wr_groups[n_groups] = '{mean: write_mean, std: write_std, count: wc};
          rd_mean_sum = rd_mean_sum + 64'(read_mean) * 64'(rc);
          rd_iops_sum = rd_iops_sum + 64'(read_iops) * 64'(rc);
          rd_cnt_sum  = rd_cnt_sum + 64'(rc);
          wr_mean_sum = wr_mean_sum + 64'(write_mean) * 64'(wc);
          wr_iops_sum = wr_iops_sum + 64'(write_iops) * 64'(wc);
          wr_cnt_sum  = wr_cnt_sum + 64'(wc);
          n_groups++;
        end else begin
          dropped = 1;
        end
        if (last_group) begin
          e.rd  = pool_side(0);
          e.wr  = pool_side(1);
          e.win = win_reg;
          e.ovf = dropped;
          expected_summaries.push_back(e);
          rd_mean_sum = 0; rd_iops_sum = 0; rd_cnt_sum = 0;
          wr_mean_sum = 0; wr_iops_sum = 0; wr_cnt_sum = 0;
          n_groups = 0;
          dropped  = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_summaries.size() == 0) begin
          report("unexpected result beat", 0, 0);
        end else begin
          e = expected_summaries.pop_front();
          if (read_valid != e.rd.ok) report("read_valid", read_valid, e.rd.ok);
          if (pooled_read_mean != e.rd.mean)
            report("pooled_read_mean", pooled_read_mean, e.rd.mean);
          if (pooled_read_std != e.rd.std)
            report("pooled_read_std", pooled_read_std, e.rd.std);
          if (pooled_read_iops != e.rd.iops)
            report("pooled_read_iops", pooled_read_iops, e.rd.iops);
          if (read_total != e.rd.total) report("read_total", read_total, e.rd.total);
          if (write_valid != e.wr.ok) report("write_valid", write_valid, e.wr.ok);
          if (pooled_write_mean != e.wr.mean)
            report("pooled_write_mean", pooled_write_mean, e.wr.mean);
          if (pooled_write_std != e.wr.std)
            report("pooled_write_std", pooled_write_std, e.wr.std);
          if (pooled_write_iops != e.wr.iops)
            report("pooled_write_iops", pooled_write_iops, e.wr.iops);
          if (write_total != e.wr.total) report("write_total", write_total, e.wr.total);
          if (window_out != e.win) report("window_out", window_out, e.win);
          if (overflowed != e.ovf) report("overflowed", overflowed, e.ovf);
        end
      end
    end
    pending = expected_summaries.size();
  end

endmodule

### dv/pooled_mean_stddev_combiner_tb.sv
// Testbench top for the pooled mean/deviation combiner: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module pooled_mean_stddev_combiner_tb;

  localparam int MAXG       = pmsc_pkg::MAX_GROUPS_DEF;
  localparam int N_ITEMS    = 1100;
  localparam int SETTLE     = 2000;
  localparam int CYCLE_CAP  = 3000000;

  typedef struct {
    logic                       rp;
    logic [pmsc_pkg::VAL_W-1:0] rm, rs, ri;
    logic [pmsc_pkg::CNT_W-1:0] rc;
    logic                       wp;
    logic [pmsc_pkg::VAL_W-1:0] wm, ws, wi;
    logic [pmsc_pkg::CNT_W-1:0] wc;
    logic                       last;
  } group_beat_t;

  logic                         clk, rst;
  logic                         in_valid, in_ready;
  logic                         read_present, write_present, last_group;
  logic [pmsc_pkg::VAL_W-1:0]   read_mean, read_std, read_iops;
  logic [pmsc_pkg::VAL_W-1:0]   write_mean, write_std, write_iops;
  logic [pmsc_pkg::CNT_W-1:0]   read_count, write_count;
  logic                         out_valid, out_ready;
  logic                         read_valid, write_valid, overflowed;
  logic [pmsc_pkg::VAL_W-1:0]   pooled_read_mean, pooled_read_std, pooled_read_iops;
  logic [pmsc_pkg::VAL_W-1:0]   pooled_write_mean, pooled_write_std, pooled_write_iops;
  logic [pmsc_pkg::TOTAL_W-1:0] read_total, write_total;
  logic [pmsc_pkg::WIN_W-1:0]   window_out, window_seconds;
  logic                         cfg_valid, cfg_ready;
  int                           fail_count, pending;
  int                           sent, burst_left, rx_hold, rx_stall_pct, rx_phase, cycles;

  pooled_mean_stddev_combiner #(.MAX_GROUPS(MAXG)) DUT (.*);

  pooled_stats_checker #(.MAX_GROUPS(MAXG)) u_checker (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: a long hold-off when asked, else a stall rate that changes by phase
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      if (rx_phase == 0) rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 90);
      rx_phase = (rx_phase + 1) % 150;
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic logic [pmsc_pkg::VAL_W-1:0] pick_val();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return pmsc_pkg::VAL_W'($urandom_range(0, 4095));
      default: return pmsc_pkg::VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [pmsc_pkg::CNT_W-1:0] pick_cnt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return pmsc_pkg::CNT_W'($urandom_range(1, 20));
      default: return pmsc_pkg::CNT_W'($urandom);
    endcase
  endfunction

  function automatic group_beat_t rand_group(input logic is_last);
    group_beat_t g;
    g.rp = ($urandom_range(0, 7) != 0);
    g.rm = pick_val(); g.rs = pick_val(); g.ri = pick_val(); g.rc = pick_cnt();
    g.wp = ($urandom_range(0, 7) != 0);
    g.wm = pick_val(); g.ws = pick_val(); g.wi = pick_val(); g.wc = pick_cnt();
    g.last = is_last;
    return g;
  endfunction

  task automatic send(input group_beat_t g);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    read_present  <= g.rp; read_mean  <= g.rm; read_std  <= g.rs;
    read_iops     <= g.ri; read_count <= g.rc;
    write_present <= g.wp; write_mean <= g.wm; write_std <= g.ws;
    write_iops    <= g.wi; write_count <= g.wc;
    last_group    <= g.last;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send(rand_group(i == len - 1));
  endtask

  // drain every pending result and let the closing pass finish before a register write
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [pmsc_pkg::WIN_W-1:0] v);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    window_seconds <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    group_beat_t g;
    int len;
    rst = 1'b1; in_valid = 1'b0; out_ready = 1'b0; cfg_valid = 1'b0;
    window_seconds = '0; read_present = 1'b0; read_mean = '0; read_std = '0;
    read_iops = '0; read_count = '0; write_present = 1'b0; write_mean = '0;
    write_std = '0; write_iops = '0; write_count = '0; last_group = 1'b0;
    sent = 0; burst_left = 0; rx_hold = 0; rx_stall_pct = 0; rx_phase = 0; cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single group at full scale, window still at its reset value
    g = '{1'b1, '1, '1, '1, '1, 1'b1, '1, '1, '1, '1, 1'b1};
    send(g);
    // empty summary: zero counts
    g = '{1'b1, '0, '0, '0, '0, 1'b1, '0, '0, '0, '0, 1'b1};
    send(g);
    // both sides absent despite nonzero counts
    g = '{1'b0, '1, 24'h1234, '1, '1, 1'b0, 24'h55, '1, '1, 16'h1, 1'b1};
    send(g);
    // read only, write absent
    g = '{1'b1, 24'h100, 24'h80, 24'h2000, 16'd3, 1'b0, '1, '1, '1, '1, 1'b1};
    send(g);
    // write only
    g = '{1'b0, '1, '1, '1, '1, 1'b1, 24'h7777, 24'h10, 24'h9, 16'd7, 1'b1};
    send(g);
    // far-apart means at full deviation: pooled deviation saturates
    g = '{1'b1, '0, '1, '0, '1, 1'b1, '0, '1, '0, '1, 1'b0};
    send(g);
    g = '{1'b1, '1, '1, '1, '1, 1'b1, '1, '1, '1, '1, 1'b1};
    send(g);
    send_set(3);
    drain();
    write_window('1);
    send_set(2);
    drain();
    write_window('0);

    // long receiver hold-off while the sender keeps offering sets
    rx_hold = 4000;
    for (int k = 0; k < 12; k++) send_set($urandom_range(1, 4));

    while (sent < N_ITEMS) begin
      // a few sets run past capacity, some with the last beat dropped
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(MAXG - 1, MAXG + 6)
                                         : $urandom_range(1, 8);
      send_set(len);
      if ($urandom_range(0, 59) == 0) begin
        drain();
        write_window(pmsc_pkg::WIN_W'($urandom));
      end
    end
    drain();

    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
